FILE: rtl/core/aes_ofb_pkg.sv
// Package for the AES-256 OFB stream cipher: S-box, field helpers, constants.
// No dependencies.
package aes_ofb_pkg;

  localparam int RoundCount = 14;
  localparam int BlockBytes = 16;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_IVHI  = 3'd4;
  localparam logic [2:0] CFG_IVLO  = 3'd5;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

FILE: rtl/core/aes256_ofb_stream_cipher.sv
// Top level of the AES-256 OFB stream cipher: config registers, an iterative
// round unit shared over 14 rounds with on-the-fly key schedule, output register.
// Depends on aes_ofb_pkg.
//
// Usage: configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set
// the four key words and the IV; index 0..3 is the key, 4 and 5 the IV high
// and low halves. Each input request on the s_axis group carries one 16-byte
// block, its byte count and a restart flag; restart reloads the feedback
// register from the IV before the block. Each request yields one result
// request on m_axis with the ciphertext, bytes past the count zeroed.
// Operation: for a block with a nonzero count, the initial key add happens as
// the block is taken, then the 14 rounds run one after another through the
// single round unit, and a last step forms the output. A zero count goes
// straight to that last step. Only one block is in flight at a time: a new
// block is taken only in the idle state, after the previous one has finished,
// as the loop through the one round unit and the round-key generator allows
// no overlap. The next block is accepted once the result has moved into the
// output register, even while that register still waits.
// When the receiver stalls, the output register holds its value; a block
// that finishes meanwhile waits in its last step and no further block is
// accepted until the register drains. Reset clears the key, IV, feedback
// register and all handshake state.
module aes256_ofb_stream_cipher
  import aes_ofb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: data_high[63:0], data_low[127:64], byte_count[132:128], pad zeros
  input  logic [135:0] s_axis_tdata,
  // tuser: restart
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: cipher_high[63:0], cipher_low[127:64], valid_bytes[132:128], zeros
  output logic [135:0] m_axis_tdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]   state;
  logic [3:0]   round;
  logic [255:0] key;
  logic [127:0] iv;
  logic [127:0] feedback;
  logic [127:0] blk;
  logic [127:0] data;
  logic [4:0]   count;
  logic [255:0] rk;      // two newest round-key blocks, older in the high half
  logic [7:0]   rcon;

  logic [4:0]   in_count;
  logic [127:0] start_fb;
  logic         in_req;
  logic         out_load;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_req = s_axis_tvalid && s_axis_tready;
  assign in_count = (s_axis_tdata[132:128] > 5'd16) ? 5'd16 : s_axis_tdata[132:128];
  assign start_fb = s_axis_tuser ? iv : feedback;
  // A finished block moves into the output register once that register is free.
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Round function: byte k of the 128-bit state sits at bits [127-8k -: 8].
  logic [127:0] sr;
  logic [127:0] mc;
  logic [127:0] round_out;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[127 - 8 * (4 * c + r) -: 8] = SBOX[blk[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0 = sr[127 - 32 * c -: 8];
      a1 = sr[119 - 32 * c -: 8];
      a2 = sr[111 - 32 * c -: 8];
      a3 = sr[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      mc[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      mc[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      mc[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
  end

  // Next round-key block: four schedule words from the two previous blocks.
  // Even rounds rotate the last word and add the round constant; odd rounds
  // only substitute it.
  logic [127:0] nk;
  always_comb begin
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    if (!round[0]) begin
      t = sub_word({rk[23:0], rk[31:24]}) ^ {rcon, 24'h0};
    end else begin
      t = sub_word(rk[31:0]);
    end
    w0 = rk[255:224] ^ t;
    w1 = rk[223:192] ^ w0;
    w2 = rk[191:160] ^ w1;
    w3 = rk[159:128] ^ w2;
    nk = {w0, w1, w2, w3};
  end

  // Round key for round r (r >= 2) is nk; rounds 0 and 1 use the key halves.
  logic [127:0] cur_rk;
  assign cur_rk = (round == 4'd1) ? rk[127:0] : nk;
  assign round_out = ((round == 4'(RoundCount)) ? sr : mc) ^ cur_rk;

  logic [127:0] cipher;
  always_comb begin
    for (int k = 0; k < BlockBytes; k++) begin
      cipher[127 - 8 * k -: 8] = (5'(k) < count) ?
        (blk[127 - 8 * k -: 8] ^ data[127 - 8 * k -: 8]) : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      round <= '0;
      key <= '0;
      iv <= '0;
      feedback <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_KEY0: key[255:192] <= cfg_data;
          CFG_KEY1: key[191:128] <= cfg_data;
          CFG_KEY2: key[127:64]  <= cfg_data;
          CFG_KEY3: key[63:0]    <= cfg_data;
          CFG_IVHI: iv[127:64]   <= cfg_data;
          CFG_IVLO: iv[63:0]     <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_req) begin
            data <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
            count <= in_count;
            feedback <= start_fb;
            blk <= start_fb ^ key[255:128];
            rk <= key;
            rcon <= 8'h01;
            round <= 4'd1;
            state <= (in_count == 5'd0) ? ST_DONE : ST_ROUND;
          end
        end
        ST_ROUND: begin
          blk <= round_out;
          if (round != 4'd1) begin
            rk <= {rk[127:0], nk};
            if (round[0]) rcon <= xtime(rcon);
          end
          if (round == 4'(RoundCount)) begin
            state <= ST_DONE;
          end
          round <= round + 4'd1;
        end
        ST_DONE: begin
          if (out_load) begin
            if (count != 5'd0) feedback <= blk;
            m_axis_tdata <= {3'b000, count, cipher[63:0], cipher[127:64]};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/aes_ofb_checker.sv
// Port-level checker for the AES-256 OFB stream cipher, bound to the top level.
// Depends on aes256_ofb_stream_cipher's ports only.
module aes_ofb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A stalled result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // After a block is taken the block is busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // Reported count never exceeds sixteen.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[132:128] <= 5'd16)
    else $error("valid_bytes out of range");

endmodule

bind aes256_ofb_stream_cipher aes_ofb_checker u_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

FILE: tb/aes256_ofb_stream_cipher_tb.sv
// Self-checking testbench for the AES-256 OFB stream cipher: random block requests,
// configuration phases and a predictor that models AES-256 and the OFB chaining.
// Depends on aes_ofb_pkg and aes256_ofb_stream_cipher.
module aes256_ofb_stream_cipher_tb;
  import aes_ofb_pkg::*;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic [4:0]  valid_bytes;
  } cipher_result_t;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        restart;
  } block_req_t;

  localparam int CycleLimit = 2000000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = CFG_KEY0;
  logic [63:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // tdata: data_high[63:0], data_low[127:64], byte_count[132:128], pad zeros
  logic [135:0] s_axis_tdata = '0;
  // tuser: restart
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // tdata: cipher_high[63:0], cipher_low[127:64], valid_bytes[132:128], zeros
  logic [135:0] m_axis_tdata;

  aes256_ofb_stream_cipher uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the shadow copy of the configuration and the feedback register.
  logic [63:0]    key_regs [4];
  logic [63:0]    iv_regs [2];
  logic [127:0]   feedback;
  cipher_result_t expected_ciphers [$];
  block_req_t     pending_blocks [$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             stall_hold = 0;
  bit             hold_go = 1'b0;
  logic           long_hold = 1'b0;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Full AES-256 encryption of one 128-bit block; byte 0 is bits [127:120].
  function automatic logic [127:0] aes256_encrypt(input logic [127:0] blk);
    logic [7:0] sched [60][4];
    logic [7:0] st [16];
    logic [7:0] nx [16];
    logic [7:0] tw [4];
    logic [7:0] tmp, rcon, a0, a1, a2, a3, all;
    logic [255:0] key;
    logic [127:0] res;
    key = {key_regs[0], key_regs[1], key_regs[2], key_regs[3]};
    rcon = 8'h01;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 4; j++)
        sched[i][j] = key[255 - 8 * (4 * i + j) -: 8];
    for (int i = 8; i < 60; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = sched[i - 1][j];
      if (i % 8 == 0) begin
        tmp = tw[0];
        tw[0] = SBOX[tw[1]] ^ rcon;
        tw[1] = SBOX[tw[2]];
        tw[2] = SBOX[tw[3]];
        tw[3] = SBOX[tmp];
        rcon = gf_double(rcon);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) tw[j] = SBOX[tw[j]];
      end
      for (int j = 0; j < 4; j++) sched[i][j] = sched[i - 8][j] ^ tw[j];
    end
    for (int b = 0; b < 16; b++) st[b] = blk[127 - 8 * b -: 8] ^ sched[b / 4][b % 4];
    for (int rnd = 1; rnd <= RoundCount; rnd++) begin
      // SubBytes and ShiftRows together, then MixColumns except in the last round.
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          nx[4 * c + r] = SBOX[st[4 * ((c + r) % 4) + r]];
      if (rnd != RoundCount) begin
        for (int c = 0; c < 4; c++) begin
          a0 = nx[4 * c]; a1 = nx[4 * c + 1]; a2 = nx[4 * c + 2]; a3 = nx[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          nx[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
          nx[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
          nx[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
          nx[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int b = 0; b < 16; b++) st[b] = nx[b] ^ sched[4 * rnd + b / 4][b % 4];
    end
    for (int b = 0; b < 16; b++) res[127 - 8 * b -: 8] = st[b];
    return res;
  endfunction

  // Advances the OFB chain for one block and returns the ciphertext it yields.
  function automatic cipher_result_t ofb_next_cipher(input block_req_t blk);
    cipher_result_t r;
    logic [127:0] plain;
    logic [127:0] ct;
    int count;
    count = (blk.byte_count > 5'd16) ? 16 : int'(blk.byte_count);
    if (blk.restart) feedback = {iv_regs[0], iv_regs[1]};
    ct = '0;
    if (count != 0) begin
      feedback = aes256_encrypt(feedback);
      plain = {blk.data_high, blk.data_low};
      for (int b = 0; b < count; b++) ct[127 - 8 * b -: 8] = plain[127 - 8 * b -: 8] ^ feedback[127 - 8 * b -: 8];
    end
    r.cipher_high = ct[127:64];
    r.cipher_low = ct[63:0];
    r.valid_bytes = 5'(count);
    return r;
  endfunction

  // Driver: offers queued block requests with random gaps, always at the falling edge.
  logic req_taken;
  int   gap_left = 0;
  always @(posedge clk) req_taken <= s_axis_tvalid && s_axis_tready && !rst;

  always @(negedge clk) begin
    block_req_t blk;
    if (!rst) begin
      if (s_axis_tvalid && !req_taken) begin
        // keep offering the same request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_blocks.size() > 0) begin
        blk = pending_blocks.pop_front();
        s_axis_tdata <= {3'b000, blk.byte_count, blk.data_low, blk.data_high};
        s_axis_tuser <= blk.restart;
        s_axis_tvalid <= 1'b1;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in its own process once the sequence asks for it.
  initial begin
    wait (hold_go);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (300) @(negedge clk);
    long_hold <= 1'b0;
  end

  // Receiver readiness: random short stalls, rare long ones, and one long hold-off.
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_hold <= $urandom_range(20, 120);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin
    block_req_t blk;
    cipher_result_t got, want;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        blk.data_high = s_axis_tdata[63:0];
        blk.data_low = s_axis_tdata[127:64];
        blk.byte_count = s_axis_tdata[132:128];
        blk.restart = s_axis_tuser;
        expected_ciphers.push_back(ofb_next_cipher(blk));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.cipher_high = m_axis_tdata[63:0];
        got.cipher_low = m_axis_tdata[127:64];
        got.valid_bytes = m_axis_tdata[132:128];
        if (expected_ciphers.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = expected_ciphers.pop_front();
          if (got.cipher_high !== want.cipher_high) begin
            $display("%0t: cipher_high expected %h actual %h", $time, want.cipher_high,
                     got.cipher_high);
            error_count++;
          end
          if (got.cipher_low !== want.cipher_low) begin
            $display("%0t: cipher_low expected %h actual %h", $time, want.cipher_low,
                     got.cipher_low);
            error_count++;
          end
          if (got.valid_bytes !== want.valid_bytes) begin
            $display("%0t: valid_bytes expected %0d actual %0d", $time, want.valid_bytes,
                     got.valid_bytes);
            error_count++;
          end
        end
      end
    end
  end

  // Global watchdog.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_KEY3) key_regs[idx[1:0]] = value;
    else if (idx == CFG_IVHI) iv_regs[0] = value;
    else if (idx == CFG_IVLO) iv_regs[1] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_block(input logic [63:0] hi, input logic [63:0] lo,
                           input logic [4:0] count, input logic restart);
    block_req_t blk;
    blk.data_high = hi;
    blk.data_low = lo;
    blk.byte_count = count;
    blk.restart = restart;
    pending_blocks.push_back(blk);
  endtask

  // Waits for the block to drain so configuration can be changed safely.
  task automatic wait_idle();
    while (pending_blocks.size() > 0 || s_axis_tvalid || expected_ciphers.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [4:0] n;
    for (int i = 0; i < count; i++) begin
      // Mostly full blocks in chains, with partial, zero and oversized counts mixed in.
      case ($urandom_range(0, 19))
        0: n = 5'd0;
        1, 2: n = 5'($urandom_range(1, 15));
        3: n = 5'($urandom_range(17, 31));
        default: n = 5'd16;
      endcase
      add_block({$urandom, $urandom}, {$urandom, $urandom}, n, ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    logic [2:0] idx;
    key_regs = '{default: '0};
    iv_regs = '{default: '0};
    feedback = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the all-zero reset key and IV.
    add_block('0, '0, 5'd16, 1'b0);
    add_block('1, '1, 5'd16, 1'b0);
    add_block('1, '1, 5'd1, 1'b0);
    add_block('1, '1, 5'd15, 1'b0);
    add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd0, 1'b1);
    add_block('1, '0, 5'd16, 1'b0);
    add_block('0, '1, 5'd31, 1'b0);
    add_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd17, 1'b1);
    add_block('1, '1, 5'd8, 1'b0);
    add_block('1, '1, 5'd9, 1'b0);
    add_block('1, '1, 5'd0, 1'b0);
    add_block('1, '1, 5'd16, 1'b1);
    wait_idle();

    // Extreme settings: all ones, then the standard test-vector key and IV.
    for (int r = 0; r < 6; r++) write_register(3'(r), '1);
    add_block('0, '0, 5'd16, 1'b1);
    add_block('1, '1, 5'd16, 1'b0);
    add_block('1, '1, 5'd4, 1'b0);
    random_phase(40);
    wait_idle();
    write_register(CFG_KEY0, 64'h603deb1015ca71be);
    write_register(CFG_KEY1, 64'h2b73aef0857d7781);
    write_register(CFG_KEY2, 64'h1f352c073b6108d7);
    write_register(CFG_KEY3, 64'h2d9810a30914dff4);
    write_register(CFG_IVHI, 64'h0001020304050607);
    write_register(CFG_IVLO, 64'h08090a0b0c0d0e0f);
    add_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1'b1);
    add_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 1'b0);

    // Long receiver hold-off while requests keep coming, so the input stalls.
    for (int i = 0; i < 6; i++) add_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
    hold_go = 1'b1;
    random_phase(150);
    wait_idle();

    // Random phases with random key and IV settings, including all-zero ones.
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 6; r++) begin
        idx = 3'(r);
        if (ph == 3) write_register(idx, '0);
        else if ($urandom_range(0, 1) == 0 || ph == 0)
          write_register(idx, {$urandom, $urandom});
      end
      random_phase(130);
      wait_idle();
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
